// ----- design/seg_merge_pkg.sv -----
`default_nettype none

package seg_merge_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int TOL_WIDTH           = 31;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_ADDR_WIDTH      = 4;
   localparam int CSR_DATA_WIDTH      = 32;

   localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(65536);

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] CSR_IDX_MODE  = 2'd0;
   localparam logic [1:0] CSR_IDX_TOL_X = 2'd1;
   localparam logic [1:0] CSR_IDX_TOL_Y = 2'd2;

   // Classification bits that travel with each segment from front to back.
   typedef struct packed {
      logic mode;
      logic split;
      logic list_end;
   } item_ctrl_type;

   localparam int CTRL_WIDTH = $bits(item_ctrl_type);

endpackage

`default_nettype wire

// ----- design/seg_merge_fifo.sv -----
`default_nettype none

module seg_merge_fifo
   import seg_merge_pkg::*;
#(
   parameter int WIDTH = 4 * COORD_WIDTH_DEFAULT + 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == NW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH))
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + NW'(1)))
      else $error("push without pop did not grow the queue");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - NW'(1)))
      else $error("pop without push did not shrink the queue");

endmodule

`default_nettype wire

// ----- design/seg_merge_front.sv -----
`default_nettype none

module seg_merge_front
   import seg_merge_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic signed [COORD_WIDTH-1:0] start_x,
   input  wire logic signed [COORD_WIDTH-1:0] start_y,
   input  wire logic signed [COORD_WIDTH-1:0] end_x,
   input  wire logic signed [COORD_WIDTH-1:0] end_y,
   input  wire logic                          list_end,
   input  wire logic                          axis_mode,
   input  wire logic [TOL_WIDTH-1:0]          tolerance_x,
   input  wire logic [TOL_WIDTH-1:0]          tolerance_y,
   output item_ctrl_type                      ctrl
);

   // Wide enough for an exact coordinate difference and for the tolerance.
   localparam int DW = (COORD_WIDTH + 1 > TOL_WIDTH + 1) ? COORD_WIDTH + 1 : TOL_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] prev_across_ff, prev_along_end_ff;
   logic signed [COORD_WIDTH-1:0] across, along_start, along_end;
   logic [TOL_WIDTH-1:0]          tol_across, tol_along;
   logic signed [DW-1:0]          diff_across, diff_along;
   logic signed [DW-1:0]          tol_across_ext, tol_along_ext;
   logic                          split;

   always_comb begin
      if (axis_mode) begin
         across      = start_y;
         along_start = start_x;
         along_end   = end_x;
         tol_across  = tolerance_y;
         tol_along   = tolerance_x;
      end else begin
         across      = start_x;
         along_start = start_y;
         along_end   = end_y;
         tol_across  = tolerance_x;
         tol_along   = tolerance_y;
      end
   end

   assign diff_across = {{(DW - COORD_WIDTH){across[COORD_WIDTH-1]}}, across}
                      - {{(DW - COORD_WIDTH){prev_across_ff[COORD_WIDTH-1]}}, prev_across_ff};
   assign diff_along  = {{(DW - COORD_WIDTH){along_start[COORD_WIDTH-1]}}, along_start}
                      - {{(DW - COORD_WIDTH){prev_along_end_ff[COORD_WIDTH-1]}},
                         prev_along_end_ff};
   assign tol_across_ext = {{(DW - TOL_WIDTH){1'b0}}, tol_across};
   assign tol_along_ext  = {{(DW - TOL_WIDTH){1'b0}}, tol_along};

   // The split decision only needs the previous raw segment, so it is made here.
   // The back end ignores it when nothing is pending.
   assign split = (diff_across > tol_across_ext) || (diff_along > tol_along_ext);
   assign ctrl  = {axis_mode, split, list_end};

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_across_ff    <= '0;
         prev_along_end_ff <= '0;
      end else if (accept) begin
         prev_across_ff    <= across;
         prev_along_end_ff <= along_end;
      end
   end

endmodule

`default_nettype wire

// ----- design/seg_merge_back.sv -----
`default_nettype none

module seg_merge_back
   import seg_merge_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [4*COORD_WIDTH+CTRL_WIDTH-1:0] item_data,
   input  wire logic                                 item_empty,
   output logic                                      item_pop,
   output logic [4*COORD_WIDTH:0]                    res_data,
   input  wire logic                                 res_full,
   output logic                                      res_push
);

   localparam int CW = COORD_WIDTH;

   item_ctrl_type          ctrl;
   logic signed [CW-1:0]   hsx, hsy, hex, hey;
   logic signed [CW-1:0]   psx_ff, psy_ff, pex_ff, pey_ff;
   logic signed [CW-1:0]   psx_in, psy_in, pex_in, pey_in;
   logic signed [CW-1:0]   nsx, nsy, nex, ney;
   logic                   pending_valid_ff, pending_valid_in;
   logic                   phase_ff, phase_in;
   logic                   go, need_split, extend;

   assign {ctrl, hsx, hsy, hex, hey} = item_data;

   assign go         = !item_empty && !res_full;
   assign need_split = pending_valid_ff && ctrl.split;
   assign extend     = ctrl.mode ? (hex > pex_ff) : (hey > pey_ff);

   // Pending segment after this item is absorbed.
   always_comb begin
      nsx = psx_ff;
      nsy = psy_ff;
      nex = pex_ff;
      ney = pey_ff;
      if (!pending_valid_ff || ctrl.split) begin
         nsx = hsx;
         nsy = hsy;
         nex = hex;
         ney = hey;
      end else if (extend) begin
         nex = hex;
         ney = hey;
      end
   end

   // A split at list end needs two transfers; the second goes out in a
   // following cycle while the item stays at the head of the queue.
   always_comb begin
      item_pop         = 1'b0;
      res_push         = 1'b0;
      res_data         = {psx_ff, psy_ff, pex_ff, pey_ff, 1'b0};
      psx_in           = psx_ff;
      psy_in           = psy_ff;
      pex_in           = pex_ff;
      pey_in           = pey_ff;
      pending_valid_in = pending_valid_ff;
      phase_in         = phase_ff;
      if (go) begin
         if (phase_ff) begin
            res_push         = 1'b1;
            res_data         = {psx_ff, psy_ff, pex_ff, pey_ff, 1'b1};
            pending_valid_in = 1'b0;
            phase_in         = 1'b0;
            item_pop         = 1'b1;
         end else begin
            psx_in           = nsx;
            psy_in           = nsy;
            pex_in           = nex;
            pey_in           = ney;
            pending_valid_in = 1'b1;
            if (need_split) begin
               res_push = 1'b1;
               if (ctrl.list_end) begin
                  phase_in = 1'b1;
               end else begin
                  item_pop = 1'b1;
               end
            end else begin
               item_pop = 1'b1;
               if (ctrl.list_end) begin
                  res_push         = 1'b1;
                  res_data         = {nsx, nsy, nex, ney, 1'b1};
                  pending_valid_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff <= 1'b0;
         phase_ff         <= 1'b0;
      end else begin
         pending_valid_ff <= pending_valid_in;
         phase_ff         <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      psx_ff <= psx_in;
      psy_ff <= psy_in;
      pex_ff <= pex_in;
      pey_ff <= pey_in;
   end

   a_phase_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> pending_valid_ff)
      else $error("second flush transfer without a pending segment");

   a_phase_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!item_empty && ctrl.list_end))
      else $error("second flush transfer without its list-end item at the head");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_data[0]) |=> !pending_valid_ff)
      else $error("pending segment survived a final transfer");

endmodule

`default_nettype wire

// ----- design/axis_segment_merger_top.sv -----
`default_nettype none

// Merges a sorted stream of axis-aligned segments into runs. Segments are
// pushed through a queue-style input (req_push/req_full) and merged segments
// are popped from a queue-style output (rsp_empty/rsp_pop); final_merged marks
// the segment flushed by an item with list_end set. One segment is accepted
// per clock cycle while req_full is low. An item that both splits a run and
// ends the list stays at the head of the item queue while it gives two
// transfers through a single result write port. A result passes through the
// item queue and the result queue before it can be popped. Configuration
// (axis_mode at byte 0, tolerance_x at 4, tolerance_y at 8) is written over
// the csr_ port by the user while the block is idle, which is not enforced.
module axis_segment_merger_top
   import seg_merge_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_y,
   input  wire logic                          req_list_end,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic signed [COORD_WIDTH-1:0]      rsp_merged_start_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_merged_start_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_merged_end_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_merged_end_y,
   output logic                               rsp_final_merged,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]          csr_prdata,
   output logic                               csr_pready
);

   localparam int IW = 4 * COORD_WIDTH + CTRL_WIDTH;
   localparam int RW = 4 * COORD_WIDTH + 1;

   logic                 axis_mode_ff;
   logic [TOL_WIDTH-1:0] tolerance_x_ff, tolerance_y_ff;
   logic                 csr_write;
   logic                 req_accept;
   item_ctrl_type        front_ctrl;
   logic [IW-1:0]        item_wr_data, item_rd_data;
   logic                 item_empty, item_pop;
   logic [RW-1:0]        res_wr_data, res_rd_data;
   logic                 res_full, res_push;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_mode_ff   <= 1'b0;
         tolerance_x_ff <= TOL_RESET;
         tolerance_y_ff <= TOL_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_IDX_MODE:  axis_mode_ff   <= csr_pwdata[0];
            CSR_IDX_TOL_X: tolerance_x_ff <= csr_pwdata[TOL_WIDTH-1:0];
            CSR_IDX_TOL_Y: tolerance_y_ff <= csr_pwdata[TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_IDX_MODE:  csr_prdata = {{(CSR_DATA_WIDTH - 1){1'b0}}, axis_mode_ff};
         CSR_IDX_TOL_X: csr_prdata = {{(CSR_DATA_WIDTH - TOL_WIDTH){1'b0}}, tolerance_x_ff};
         CSR_IDX_TOL_Y: csr_prdata = {{(CSR_DATA_WIDTH - TOL_WIDTH){1'b0}}, tolerance_y_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign req_accept = req_push && !req_full;

   seg_merge_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .start_x     (req_start_x),
      .start_y     (req_start_y),
      .end_x       (req_end_x),
      .end_y       (req_end_y),
      .list_end    (req_list_end),
      .axis_mode   (axis_mode_ff),
      .tolerance_x (tolerance_x_ff),
      .tolerance_y (tolerance_y_ff),
      .ctrl        (front_ctrl)
   );

   assign item_wr_data = {front_ctrl, req_start_x, req_start_y, req_end_x, req_end_y};

   seg_merge_fifo #(
      .WIDTH (IW),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (item_wr_data),
      .full    (req_full),
      .pop     (item_pop),
      .rd_data (item_rd_data),
      .empty   (item_empty)
   );

   seg_merge_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_data  (item_rd_data),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .res_data   (res_wr_data),
      .res_full   (res_full),
      .res_push   (res_push)
   );

   seg_merge_fifo #(
      .WIDTH (RW),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr_data),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_rd_data),
      .empty   (rsp_empty)
   );

   assign {rsp_merged_start_x, rsp_merged_start_y, rsp_merged_end_x, rsp_merged_end_y,
           rsp_final_merged} = res_rd_data;

endmodule

`default_nettype wire

// ----- dv/tb_axis_segment_merger_top.sv -----
`timescale 1ns / 1ps

module tb_axis_segment_merger_top;
   import seg_merge_pkg::*;

   localparam int CW           = 32;
   localparam int PHASE_ITEMS  = 150;
   localparam int NUM_PHASES   = 8;
   localparam int SETTLE_CYCLES = 10;
   localparam longint CYCLE_LIMIT = 400000;

   localparam logic [1:0]    CSR_IDX_UNUSED = 2'd3;
   localparam logic [CW-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [CW-1:0] COORD_MIN = 32'h8000_0000;

   typedef enum bit {AXIS_VERTICAL, AXIS_HORIZONTAL} axis_mode_type;
   typedef enum bit {ROW_SEGMENT, ROW_REGISTER} row_kind_type;

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      logic                 last;
   } segment_type;

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      logic                 fin;
   } merged_type;

   typedef struct {
      row_kind_type kind;
      segment_type  seg;
      bit           typed;
      merged_type   want;
      logic [1:0]   reg_idx;
      logic [31:0]  reg_value;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic signed [CW-1:0]          req_start_x = '0;
   logic signed [CW-1:0]          req_start_y = '0;
   logic signed [CW-1:0]          req_end_x = '0;
   logic signed [CW-1:0]          req_end_y = '0;
   logic                          req_list_end = 1'b0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic signed [CW-1:0]          rsp_merged_start_x;
   logic signed [CW-1:0]          rsp_merged_start_y;
   logic signed [CW-1:0]          rsp_merged_end_x;
   logic signed [CW-1:0]          rsp_merged_end_y;
   logic                          rsp_final_merged;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]     csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_prdata;
   logic                          csr_pready;

   axis_segment_merger_top #(.COORD_WIDTH(CW)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_start_x        (req_start_x),
      .req_start_y        (req_start_y),
      .req_end_x          (req_end_x),
      .req_end_y          (req_end_y),
      .req_list_end       (req_list_end),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_merged_start_x (rsp_merged_start_x),
      .rsp_merged_start_y (rsp_merged_start_y),
      .rsp_merged_end_x   (rsp_merged_end_x),
      .rsp_merged_end_y   (rsp_merged_end_y),
      .rsp_final_merged   (rsp_final_merged),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // Shadow of the configuration and the merge state.
   axis_mode_type   cfg_mode = AXIS_VERTICAL;
   logic [30:0]     cfg_tol_x = 31'd65536;
   logic [30:0]     cfg_tol_y = 31'd65536;
   bit              run_open = 1'b0;
   merged_type      run_seg;
   longint          prev_across;
   longint          prev_along_end;

   merged_type      expected_merges[$];
   stim_row_type    directed_rows[$];

   int              error_count = 0;
   int              segments_sent = 0;
   int              merges_checked = 0;
   int              final_marks_seen = 0;
   int              settings_written = 0;
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;
   longint          cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d merges outstanding.",
                  cycle_count, expected_merges.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   task automatic expect_merge(input merged_type m);
      expected_merges = {expected_merges, m};
   endtask

   // Merge predictor: one accepted segment in, zero to two merged segments out.
   task automatic merge_segment(input segment_type seg, output int n,
                                output merged_type r0, output merged_type r1);
      longint across, along_start, along_end, run_end, tol_across, tol_along;
      if (cfg_mode == AXIS_VERTICAL) begin
         across      = longint'($signed(seg.sx));
         along_start = longint'($signed(seg.sy));
         along_end   = longint'($signed(seg.ey));
         run_end     = longint'($signed(run_seg.ey));
         tol_across  = longint'(cfg_tol_x);
         tol_along   = longint'(cfg_tol_y);
      end else begin
         across      = longint'($signed(seg.sy));
         along_start = longint'($signed(seg.sx));
         along_end   = longint'($signed(seg.ex));
         run_end     = longint'($signed(run_seg.ex));
         tol_across  = longint'(cfg_tol_y);
         tol_along   = longint'(cfg_tol_x);
      end
      n  = 0;
      r0 = '0;
      r1 = '0;
      if (!run_open) begin
         run_seg  = {seg.sx, seg.sy, seg.ex, seg.ey, 1'b0};
         run_open = 1'b1;
      end else if (across - prev_across > tol_across ||
                   along_start - prev_along_end > tol_along) begin
         r0       = run_seg;
         r0.fin   = 1'b0;
         n        = 1;
         run_seg  = {seg.sx, seg.sy, seg.ex, seg.ey, 1'b0};
      end else if (run_end < along_end) begin
         run_seg.ex = seg.ex;
         run_seg.ey = seg.ey;
      end
      prev_across    = across;
      prev_along_end = along_end;
      if (seg.last) begin
         if (n == 0) begin
            r0     = run_seg;
            r0.fin = 1'b1;
         end else begin
            r1     = run_seg;
            r1.fin = 1'b1;
         end
         n++;
         run_open = 1'b0;
      end
   endtask

   task automatic send_segment(input segment_type seg, input bit typed,
                               input merged_type want);
      int         n;
      merged_type r0, r1;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push     <= 1'b1;
      req_start_x  <= seg.sx;
      req_start_y  <= seg.sy;
      req_end_x    <= seg.ex;
      req_end_y    <= seg.ey;
      req_list_end <= seg.last;
      do @(posedge clock); while (req_full);
      segments_sent++;
      merge_segment(seg, n, r0, r1);
      if (typed) begin
         expect_merge(want);
      end else begin
         if (n > 0) expect_merge(r0);
         if (n > 1) expect_merge(r1);
      end
   endtask

   // Lowers push, waits for every merge to come out, then lets the pipeline settle.
   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_merges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_IDX_MODE:  cfg_mode  = axis_mode_type'(value[0]);
         CSR_IDX_TOL_X: cfg_tol_x = value[30:0];
         CSR_IDX_TOL_Y: cfg_tol_y = value[30:0];
         default: ;
      endcase
      settings_written++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_IDX_MODE:
            if (readback !== {31'b0, cfg_mode}) report_mismatch("axis_mode readback",
               readback, cfg_mode);
         CSR_IDX_TOL_X:
            if (readback !== {1'b0, cfg_tol_x}) report_mismatch("tolerance_x readback",
               readback, cfg_tol_x);
         CSR_IDX_TOL_Y:
            if (readback !== {1'b0, cfg_tol_y}) report_mismatch("tolerance_y readback",
               readback, cfg_tol_y);
         default: ;
      endcase
   endtask

   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      merged_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_merges.size() == 0) begin
            report_mismatch("unexpected merged segment, start_x", rsp_merged_start_x, 0);
         end else begin
            want = expected_merges.pop_front();
            merges_checked++;
            if (rsp_final_merged === 1'b1) final_marks_seen++;
            if (rsp_merged_start_x !== want.sx)
               report_mismatch("merged_start_x", rsp_merged_start_x, want.sx);
            if (rsp_merged_start_y !== want.sy)
               report_mismatch("merged_start_y", rsp_merged_start_y, want.sy);
            if (rsp_merged_end_x !== want.ex)
               report_mismatch("merged_end_x", rsp_merged_end_x, want.ex);
            if (rsp_merged_end_y !== want.ey)
               report_mismatch("merged_end_y", rsp_merged_end_y, want.ey);
            if (rsp_final_merged !== want.fin)
               report_mismatch("final_merged", rsp_final_merged, want.fin);
         end
      end
   end

   function automatic logic [CW-1:0] fx(input int v);
      return CW'(v <<< 16);
   endfunction

   task automatic add_segment(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                              input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                              input bit last, input bit typed);
      stim_row_type row;
      row.kind      = ROW_SEGMENT;
      row.seg       = {sx, sy, ex, ey, last};
      row.typed     = typed;
      // A lone segment in a list comes back as itself, marked final.
      row.want      = {sx, sy, ex, ey, 1'b1};
      row.reg_idx   = CSR_IDX_MODE;
      row.reg_value = '0;
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_register(input logic [1:0] idx, input logic [31:0] value);
      stim_row_type row;
      row.kind      = ROW_REGISTER;
      row.seg       = '0;
      row.typed     = 1'b0;
      row.want      = '0;
      row.reg_idx   = idx;
      row.reg_value = value;
      directed_rows = {directed_rows, row};
   endtask

   function automatic logic [CW-1:0] pick_step(input logic [30:0] tol);
      case ($urandom_range(5))
         0: return '0;
         1: return {1'b0, tol};
         2: return {1'b0, tol} + 1;
         3: return {1'b0, tol} - 1;
         4: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom & {1'b0, tol};
      endcase
   endfunction

   // Mostly sorted lists with random content; the rest is raw noise and
   // lists that step backwards.
   task automatic run_random_lists(input int count);
      int            sent;
      int            list_len;
      int            k;
      logic [CW-1:0] across, along_s, along_e, prev_end;
      logic [30:0]   tol_across, tol_along;
      segment_type   seg;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 15) begin
            seg = {$urandom, $urandom, $urandom, $urandom, 1'($urandom_range(3) == 0)};
            send_segment(seg, 1'b0, '0);
            sent++;
         end else begin
            tol_across = (cfg_mode == AXIS_VERTICAL) ? cfg_tol_x : cfg_tol_y;
            tol_along  = (cfg_mode == AXIS_VERTICAL) ? cfg_tol_y : cfg_tol_x;
            list_len   = $urandom_range(1, 12);
            across     = $urandom;
            prev_end   = $urandom;
            for (k = 0; k < list_len && sent < count; k++) begin
               if (k == 0) begin
                  along_s = prev_end;
               end else if ($urandom_range(99) < 8) begin
                  across  = across - $urandom_range(0, 32'h0002_0000);
                  along_s = prev_end - $urandom_range(0, 32'h0008_0000);
               end else begin
                  if ($urandom_range(2) == 0) across = across + pick_step(tol_across);
                  along_s = prev_end + pick_step(tol_along);
               end
               along_e = along_s +
                         (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 32'h0008_0000));
               if (cfg_mode == AXIS_VERTICAL)
                  seg = {across, along_s, across, along_e, 1'(k == list_len - 1)};
               else
                  seg = {along_s, across, along_e, across, 1'(k == list_len - 1)};
               send_segment(seg, 1'b0, '0);
               prev_end = along_e;
               sent++;
            end
         end
      end
   endtask

   initial begin
      int phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Vertical mode, reset tolerances of one unit.
      add_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
      add_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1);
      add_segment(fx(1), fx(0), fx(1), fx(5), 1'b0, 1'b0);
      add_segment(fx(1), fx(5), fx(1), fx(8), 1'b0, 1'b0);
      // Across step and along gap both exactly at the tolerance still merge.
      add_segment(fx(2), fx(9), fx(2), fx(12), 1'b0, 1'b0);
      add_segment(fx(2), fx(10), fx(2), fx(11), 1'b0, 1'b0);
      add_segment(fx(2), fx(14), fx(2), fx(20), 1'b0, 1'b0);
      add_segment(fx(4), fx(20), fx(4), fx(25), 1'b0, 1'b0);
      add_segment(fx(-100), fx(0), fx(-100), fx(3), 1'b0, 1'b0);
      add_segment(fx(50), fx(0), fx(50), fx(1), 1'b1, 1'b0);
      // Differences across the full coordinate range must not wrap.
      add_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
      add_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
      add_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
      add_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
      // Horizontal mode with the tolerance extremes; upper bits must be masked.
      add_register(CSR_IDX_MODE, 32'hFFFF_FFFF);
      add_register(CSR_IDX_TOL_X, 32'h0000_0000);
      add_register(CSR_IDX_TOL_Y, 32'hFFFF_FFFF);
      add_register(CSR_IDX_UNUSED, 32'h0000_0000);
      add_segment(fx(0), fx(3), fx(5), fx(3), 1'b0, 1'b0);
      add_segment(fx(5), fx(3), fx(7), fx(3), 1'b0, 1'b0);
      add_segment(fx(8), fx(3), fx(9), fx(3), 1'b0, 1'b0);
      add_segment(fx(9), COORD_MAX, fx(12), COORD_MAX, 1'b0, 1'b0);
      add_segment(fx(12), COORD_MIN, fx(13), COORD_MIN, 1'b1, 1'b0);
      // A run opened in horizontal mode continues after a switch to vertical.
      add_segment(fx(0), fx(0), fx(4), fx(0), 1'b0, 1'b0);
      add_register(CSR_IDX_MODE, 32'hFFFF_FFFE);
      add_register(CSR_IDX_TOL_X, 32'h0001_0000);
      add_register(CSR_IDX_TOL_Y, 32'h0001_0000);
      add_segment(fx(0), fx(0), fx(0), fx(4), 1'b0, 1'b0);
      add_segment(fx(0), fx(4), fx(0), fx(6), 1'b1, 1'b0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REGISTER) begin
            wait_idle();
            write_register(directed_rows[i].reg_idx, directed_rows[i].reg_value);
         end else begin
            send_segment(directed_rows[i].seg, directed_rows[i].typed,
                         directed_rows[i].want);
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_register(CSR_IDX_MODE, AXIS_VERTICAL);
               write_register(CSR_IDX_TOL_X, 32'h0001_0000);
               write_register(CSR_IDX_TOL_Y, 32'h0001_0000);
            end
            1: begin
               write_register(CSR_IDX_MODE, AXIS_HORIZONTAL);
               write_register(CSR_IDX_TOL_X, 32'h0);
               write_register(CSR_IDX_TOL_Y, 32'h0);
            end
            2: begin
               write_register(CSR_IDX_MODE, AXIS_VERTICAL);
               write_register(CSR_IDX_TOL_X, 32'h7FFF_FFFF);
               write_register(CSR_IDX_TOL_Y, 32'h7FFF_FFFF);
            end
            3, 4: begin
               write_register(CSR_IDX_MODE, (phase == 3) ? AXIS_HORIZONTAL : AXIS_VERTICAL);
               write_register(CSR_IDX_TOL_X, $urandom_range(0, 32'h0004_0000));
               write_register(CSR_IDX_TOL_Y, $urandom_range(0, 32'h0004_0000));
            end
            5: begin
               write_register(CSR_IDX_MODE, AXIS_HORIZONTAL);
               write_register(CSR_IDX_TOL_X, 32'h7FFF_FFFF);
               write_register(CSR_IDX_TOL_Y, 32'h0);
            end
            6: begin
               write_register(CSR_IDX_MODE, AXIS_VERTICAL);
               write_register(CSR_IDX_TOL_X, 32'h0);
               write_register(CSR_IDX_TOL_Y, 32'h7FFF_FFFF);
            end
            default: begin
               write_register(CSR_IDX_MODE, $urandom);
               write_register(CSR_IDX_TOL_X, $urandom);
               write_register(CSR_IDX_TOL_Y, $urandom);
            end
         endcase
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
            default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
         endcase
         run_random_lists(PHASE_ITEMS);
      end

      wait_idle();
      if (expected_merges.size() != 0)
         report_mismatch("merged segments never delivered", 0, expected_merges.size());
      $display("Sent %0d segments under %0d register writes in both axis modes.",
               segments_sent, settings_written);
      $display("Compared %0d merged segments, %0d of them list flushes; %0d mismatches.",
               merges_checked, final_marks_seen, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
